// ===== sv/ps2mct_pkg.sv =====
`timescale 1ns / 1ps
package ps2mct_pkg;

    localparam int REG_BITS   = 12;
    localparam int CFG_IDX_BITS = 8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT_X = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT_Y = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_X = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_Y = 8'd3;

    localparam logic [REG_BITS-1:0] LIMIT_X_RST = 12'd992;
    localparam logic [REG_BITS-1:0] LIMIT_Y_RST = 12'd736;
    localparam logic [REG_BITS-1:0] START_X_RST = 12'd512;
    localparam logic [REG_BITS-1:0] START_Y_RST = 12'd384;

    localparam int HDR_SYNC_BIT = 3;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;

    localparam logic [1:0] IDX_HEADER = 2'd0;
    localparam logic [1:0] IDX_DX     = 2'd1;
    localparam logic [1:0] IDX_DY     = 2'd2;

    typedef struct packed {
        logic       emit;
        logic       hdr_we;
        logic       dx_we;
        logic [1:0] idx_n;
    } t_step_ctl;

endpackage

// ===== sv/ps2mct_step.sv =====
`timescale 1ns / 1ps
module ps2mct_step #(
    parameter int COORD_BITS = 12
) (
    input  logic                          i_valid,
    input  logic [7:0]                    i_data,
    input  logic                          i_gate,
    input  logic [1:0]                    i_idx,
    input  logic [7:0]                    i_header,
    input  logic [7:0]                    i_dx,
    input  logic [COORD_BITS-1:0]         i_pos_x,
    input  logic [COORD_BITS-1:0]         i_pos_y,
    input  logic [ps2mct_pkg::REG_BITS-1:0] i_limit_x,
    input  logic [ps2mct_pkg::REG_BITS-1:0] i_limit_y,
    output ps2mct_pkg::t_step_ctl         o_ctl,
    output logic [COORD_BITS-1:0]         o_pos_x,
    output logic [COORD_BITS-1:0]         o_pos_y
);
    import ps2mct_pkg::*;

    localparam int WB = (COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS;
    localparam int SW = WB + 2;

    logic signed [8:0]    dx9;
    logic signed [8:0]    dy9;
    logic signed [SW-1:0] sum_x;
    logic signed [SW-1:0] sum_y;
    logic signed [SW-1:0] cmax;
    logic signed [SW-1:0] hi_x;
    logic signed [SW-1:0] hi_y;
    logic signed [SW-1:0] lim_x;
    logic signed [SW-1:0] lim_y;
    logic signed [SW-1:0] cl_x;
    logic signed [SW-1:0] cl_y;

    always_comb begin
        dx9 = {i_header[HDR_XSIGN_BIT], i_dx};
        dy9 = {i_header[HDR_YSIGN_BIT], i_data};
        // -256 reads as no motion
        if (dx9 == -9'sd256) begin
            dx9 = 9'sd0;
        end
        if (dy9 == -9'sd256) begin
            dy9 = 9'sd0;
        end
        sum_x = $signed({{(SW-COORD_BITS){1'b0}}, i_pos_x}) + SW'(dx9);
        sum_y = $signed({{(SW-COORD_BITS){1'b0}}, i_pos_y}) - SW'(dy9);
        cmax  = $signed({{(SW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}});
        lim_x = $signed({{(SW-REG_BITS){1'b0}}, i_limit_x});
        lim_y = $signed({{(SW-REG_BITS){1'b0}}, i_limit_y});
        hi_x  = (lim_x > cmax) ? cmax : lim_x;
        hi_y  = (lim_y > cmax) ? cmax : lim_y;
        if (sum_x < 0) begin
            cl_x = '0;
        end else if (sum_x > hi_x) begin
            cl_x = hi_x;
        end else begin
            cl_x = sum_x;
        end
        if (sum_y < 0) begin
            cl_y = '0;
        end else if (sum_y > hi_y) begin
            cl_y = hi_y;
        end else begin
            cl_y = sum_y;
        end
        o_pos_x = cl_x[COORD_BITS-1:0];
        o_pos_y = cl_y[COORD_BITS-1:0];
    end

    always_comb begin
        o_ctl = '0;
        o_ctl.idx_n = i_idx;
        if (i_valid && i_gate) begin
            unique case (i_idx)
                IDX_HEADER: begin
                    if (i_data[HDR_SYNC_BIT]) begin
                        o_ctl.hdr_we = 1'b1;
                        o_ctl.idx_n  = IDX_DX;
                    end
                end
                IDX_DX: begin
                    o_ctl.dx_we = 1'b1;
                    o_ctl.idx_n = IDX_DY;
                end
                default: begin
                    o_ctl.emit  = 1'b1;
                    o_ctl.idx_n = IDX_HEADER;
                end
            endcase
        end
    end

endmodule

// ===== sv/ps2_mouse_cursor_tracker_unit.sv =====
`timescale 1ns / 1ps
// A packet-closing byte passes the input reg, then the result reg, before cursor valid.
// Throughput: one byte per cycle; a held result blocks only a packet-closing byte.
// Reset (sync, active low): packet index to header, limits to 992/736,
// cursor to 512/384, no result pending.
module ps2_mouse_cursor_tracker_unit #(
    parameter int COORD_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_buffer_full,
    input  logic                              i_from_aux,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [ps2mct_pkg::REG_BITS-1:0]   o_cursor_x,
    output logic [ps2mct_pkg::REG_BITS-1:0]   o_cursor_y,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ps2mct_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [ps2mct_pkg::REG_BITS-1:0]   i_cfg_data
);
    import ps2mct_pkg::*;

    logic                  r_s1_valid;
    logic [7:0]            r_s1_data;
    logic                  r_s1_gate;
    logic [1:0]            r_idx;
    logic [7:0]            r_header;
    logic [7:0]            r_dx;
    logic [COORD_BITS-1:0] r_pos_x;
    logic [COORD_BITS-1:0] r_pos_y;
    logic [REG_BITS-1:0]   r_limit_x;
    logic [REG_BITS-1:0]   r_limit_y;
    logic                  r_out_valid;
    logic [REG_BITS-1:0]   r_cursor_x;
    logic [REG_BITS-1:0]   r_cursor_y;

    t_step_ctl             ctl;
    logic [COORD_BITS-1:0] n_pos_x;
    logic [COORD_BITS-1:0] n_pos_y;
    logic [COORD_BITS+REG_BITS-1:0] ext_x;
    logic [COORD_BITS+REG_BITS-1:0] ext_y;
    logic                  out_busy;
    logic                  s1_go;
    logic                  s1_free;
    logic                  in_fire;

    ps2mct_step #(
        .COORD_BITS(COORD_BITS)
    ) u_step (
        .i_valid   (r_s1_valid),
        .i_data    (r_s1_data),
        .i_gate    (r_s1_gate),
        .i_idx     (r_idx),
        .i_header  (r_header),
        .i_dx      (r_dx),
        .i_pos_x   (r_pos_x),
        .i_pos_y   (r_pos_y),
        .i_limit_x (r_limit_x),
        .i_limit_y (r_limit_y),
        .o_ctl     (ctl),
        .o_pos_x   (n_pos_x),
        .o_pos_y   (n_pos_y)
    );

    assign out_busy    = r_out_valid && i_stall;
    assign s1_go       = r_s1_valid && !(ctl.emit && out_busy);
    assign s1_free     = !r_s1_valid || s1_go;
    assign in_fire     = i_valid && s1_free;
    assign o_stall     = !s1_free;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_cursor_x  = r_cursor_x;
    assign o_cursor_y  = r_cursor_y;
    assign ext_x       = {{REG_BITS{1'b0}}, n_pos_x};
    assign ext_y       = {{REG_BITS{1'b0}}, n_pos_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_fire || (r_s1_valid && !s1_go);
        end
        if (in_fire) begin
            r_s1_data <= i_data_byte;
            r_s1_gate <= i_buffer_full && i_from_aux;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= IDX_HEADER;
            r_pos_x <= COORD_BITS'(START_X_RST);
            r_pos_y <= COORD_BITS'(START_Y_RST);
        end else if (s1_go) begin
            r_idx <= ctl.idx_n;
            if (ctl.emit) begin
                r_pos_x <= n_pos_x;
                r_pos_y <= n_pos_y;
            end
        end
        if (s1_go && ctl.hdr_we) begin
            r_header <= r_s1_data;
        end
        if (s1_go && ctl.dx_we) begin
            r_dx <= r_s1_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (s1_go && ctl.emit) begin
            r_cursor_x <= ext_x[REG_BITS-1:0];
            r_cursor_y <= ext_y[REG_BITS-1:0];
        end
    end

    // start position is only loaded at reset, which also restores its default
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_x <= LIMIT_X_RST;
            r_limit_y <= LIMIT_Y_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index) inside
                CFG_LIMIT_X: r_limit_x <= i_cfg_data;
                CFG_LIMIT_Y: r_limit_y <= i_cfg_data;
                CFG_START_X, CFG_START_Y: begin
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== tb/sv/ps2_mouse_cursor_tracker_unit_tb.sv =====
`timescale 1ns / 1ps
module ps2_mouse_cursor_tracker_unit_tb;
    import ps2mct_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [REG_BITS-1:0] x;
        logic [REG_BITS-1:0] y;
    } t_cursor;

    class t_cursor_scoreboard;
        logic [1:0]          pkt_idx;
        logic [7:0]          hdr;
        logic [7:0]          dx_raw;
        int                  pos_x;
        int                  pos_y;
        logic [REG_BITS-1:0] limit_x;
        logic [REG_BITS-1:0] limit_y;
        logic [REG_BITS-1:0] start_x;
        logic [REG_BITS-1:0] start_y;
        t_cursor             cursor_q[$];
        int                  errors;

        function new();
            limit_x = LIMIT_X_RST;
            limit_y = LIMIT_Y_RST;
            start_x = START_X_RST;
            start_y = START_Y_RST;
            pkt_idx = IDX_HEADER;
            hdr     = '0;
            dx_raw  = '0;
            pos_x   = int'(start_x);
            pos_y   = int'(start_y);
            errors  = 0;
        endfunction

        // start registers only matter at reset, which happens once
        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [REG_BITS-1:0] val);
            case (idx)
                CFG_LIMIT_X: limit_x = val;
                CFG_LIMIT_Y: limit_y = val;
                CFG_START_X: start_x = val;
                CFG_START_Y: start_y = val;
                default: ;
            endcase
        endfunction

        function int delta9(logic [7:0] low, logic neg);
            int d;
            d = int'(low);
            if (neg) d -= 256;
            if (d == -256) d = 0;
            return d;
        endfunction

        function int clip(int v, logic [REG_BITS-1:0] lim);
            if (v < 0) return 0;
            if (v > int'(lim)) return int'(lim);
            return v;
        endfunction

        function int pending();
            return cursor_q.size();
        endfunction

        function void track_byte(logic [7:0] b, logic full, logic aux);
            t_cursor c;
            if (!(full && aux)) return;
            if (pkt_idx == IDX_HEADER) begin
                if (b[HDR_SYNC_BIT]) begin
                    hdr     = b;
                    pkt_idx = IDX_DX;
                end
                return;
            end
            if (pkt_idx == IDX_DX) begin
                dx_raw  = b;
                pkt_idx = IDX_DY;
                return;
            end
            pkt_idx = IDX_HEADER;
            pos_x = clip(pos_x + delta9(dx_raw, hdr[HDR_XSIGN_BIT]), limit_x);
            pos_y = clip(pos_y - delta9(b, hdr[HDR_YSIGN_BIT]), limit_y);
            c.x = pos_x[REG_BITS-1:0];
            c.y = pos_y[REG_BITS-1:0];
            cursor_q.push_back(c);
        endfunction

        function void check_cursor(logic [REG_BITS-1:0] x, logic [REG_BITS-1:0] y);
            t_cursor e;
            if (cursor_q.size() == 0) begin
                $display("%0t: unexpected cursor transfer x=%0d y=%0d", $time, x, y);
                errors++;
                return;
            end
            e = cursor_q.pop_front();
            if (x !== e.x) begin
                $display("%0t: cursor_x expected %0d, got %0d", $time, e.x, x);
                errors++;
            end
            if (y !== e.y) begin
                $display("%0t: cursor_y expected %0d, got %0d", $time, e.y, y);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [7:0]              i_data_byte = '0;
    logic                    i_buffer_full = 1'b0;
    logic                    i_from_aux = 1'b0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [REG_BITS-1:0]     o_cursor_x;
    logic [REG_BITS-1:0]     o_cursor_y;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [REG_BITS-1:0]     i_cfg_data = '0;

    t_cursor_scoreboard sb;
    bit tx_gaps_on = 1'b1;
    bit rx_stall_on = 1'b1;
    int sign_bias = 0;
    int stall_left = 0;
    int run_left = 0;
    int idle_cycles = 0;

    ps2_mouse_cursor_tracker_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_buffer_full(i_buffer_full),
        .i_from_aux   (i_from_aux),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cursor_x   (o_cursor_x),
        .o_cursor_y   (o_cursor_y),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // cursor side: check, then choose next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_cursor(o_cursor_x, o_cursor_y);
        if (!rx_stall_on) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (run_left > 0) begin
            run_left <= run_left - 1;
            i_stall  <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            run_left   <= $urandom_range(0, 10);
            i_stall    <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic full, input logic aux);
        int gap;
        i_valid       <= 1'b1;
        i_data_byte   <= b;
        i_buffer_full <= full;
        i_from_aux    <= aux;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.track_byte(b, full, aux);
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_gated();
        logic [1:0] fa;
        fa = 2'($urandom_range(0, 2));
        send_byte(8'($urandom_range(0, 255)), fa[1], fa[0]);
    endtask

    task automatic packet(input logic [7:0] hdr, input logic [7:0] dx, input logic [7:0] dy);
        send_byte(hdr, 1'b1, 1'b1);
        send_byte(dx, 1'b1, 1'b1);
        send_byte(dy, 1'b1, 1'b1);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic write_regs(input logic [REG_BITS-1:0] lx, ly, sx, sy);
        cfg_write(CFG_LIMIT_X, lx);
        cfg_write(CFG_LIMIT_Y, ly);
        cfg_write(CFG_START_X, sx);
        cfg_write(CFG_START_Y, sy);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] rand_delta();
        if ($urandom_range(0, 7) == 0) return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic run_random(input int n_bytes, input bit pause_mid);
        int         sent;
        int         r;
        bit         paused;
        logic [7:0] hdr;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_bytes) begin
            if (pause_mid && !paused && sent >= n_bytes / 2) begin
                // hold off input until every cursor is out
                paused = 1'b1;
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending() != 0) @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (r < 12) begin
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                sent += 1;
            end else if (r < 20) begin
                // truncated packet
                send_byte(8'($urandom_range(0, 255)) | 8'h08, 1'b1, 1'b1);
                sent += 1;
                if ($urandom_range(0, 1)) begin
                    send_byte(rand_delta(), 1'b1, 1'b1);
                    sent += 1;
                end
            end else begin
                hdr = 8'($urandom_range(0, 255)) | 8'h08;
                if (sign_bias == 1 && $urandom_range(0, 3) != 0) hdr = hdr & 8'hCF;
                if (sign_bias == 2 && $urandom_range(0, 3) != 0) hdr = hdr | 8'h30;
                if ($urandom_range(0, 11) == 0) begin
                    send_gated();
                    sent += 1;
                end
                send_byte(hdr, 1'b1, 1'b1);
                if ($urandom_range(0, 11) == 0) begin
                    send_gated();
                    sent += 1;
                end
                send_byte(rand_delta(), 1'b1, 1'b1);
                if ($urandom_range(0, 11) == 0) begin
                    send_gated();
                    sent += 1;
                end
                send_byte(rand_delta(), 1'b1, 1'b1);
                sent += 3;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // first packet shows the start position is clamped only then
        write_regs(LIMIT_X_RST, 12'd100, START_X_RST, START_Y_RST);

        send_byte(8'h08, 1'b0, 1'b1);
        send_byte(8'h08, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        packet(8'h08, 8'h00, 8'h00);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hF7, 1'b1, 1'b1);
        packet(8'h08, 8'hFF, 8'hFF);
        packet(8'h38, 8'h00, 8'h00);
        packet(8'h38, 8'h01, 8'h01);
        packet(8'hFF, 8'h80, 8'h7F);
        send_byte(8'h08, 1'b1, 1'b1);
        send_byte(8'hAA, 1'b1, 1'b0);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h08, 1'b1, 1'b1);

        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            case (ph)
                0: write_regs(12'd0, 12'd0, 12'd4095, 12'd0);
                1: write_regs(12'd4095, 12'd4095, 12'd0, 12'd4095);
                2: write_regs(LIMIT_X_RST, LIMIT_Y_RST, START_X_RST, START_Y_RST);
                3: write_regs(12'($urandom_range(0, 60)), 12'($urandom_range(0, 60)),
                              12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
                default: write_regs(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                                    12'($urandom_range(0, 4095)),
                                    12'($urandom_range(0, 4095)));
            endcase
            tx_gaps_on  = (ph != 2);
            rx_stall_on = (ph != 4);
            sign_bias   = (ph == 5) ? 2 : (ph % 3);
            run_random(125, ph == 1);
        end

        wait_idle();
        repeat (6) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
sv/ps2mct_pkg.sv
sv/ps2mct_step.sv
sv/ps2_mouse_cursor_tracker_unit.sv
tb/sv/ps2_mouse_cursor_tracker_unit_tb.sv
